### src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

### src/lfsrc_pkg.sv
// Shared types, widths and constants of the line-follower drive sequencer.
package lfsrc_pkg;

   localparam int unsigned REQ_W      = 2;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned FLAGS_W    = 8;
   localparam int unsigned DEV_W      = 13;
   localparam int unsigned SPEED_W    = 14;
   localparam int unsigned FRAMES_W   = 8;
   localparam int unsigned RAMP_W     = 16;
   localparam int unsigned TARGET_W   = 16;
   localparam int unsigned Q16_W      = 17;
   localparam int unsigned PROD_W     = 2 * Q16_W;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned DIV_STEPS  = RAMP_W;
   localparam int unsigned STEP_W     = $clog2(DIV_STEPS);

   // request codes
   localparam logic [REQ_W-1:0] REQ_START = 2'd0;
   localparam logic [REQ_W-1:0] REQ_LINE  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_DRIVE = 2'd2;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_BASE_SPEED  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_STOP_FRAMES = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RAMP_TIME   = 2'd2;

   localparam logic [SPEED_W-1:0]  BASE_SPEED_RST  = 14'd590;
   localparam logic [FRAMES_W-1:0] STOP_FRAMES_RST = 8'd3;
   localparam logic [RAMP_W-1:0]   RAMP_TIME_RST   = 16'd800;

   localparam logic [TIME_W-1:0]   LINE_START_MS  = 32'd15000;
   localparam logic [TIME_W-1:0]   LOST_STOP_MS   = 32'd500;
   localparam logic [2:0]          LINE_BLACK_MIN = 3'd3;
   localparam logic [FRAMES_W-1:0] FRAMES_MAX     = 8'hFF;
   localparam logic [Q16_W-1:0]    Q16_ONE        = 17'h10000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_UP_INIT,
      ST_DIV_UP,
      ST_SQ_UP,
      ST_UP_SAVE,
      ST_DN_INIT,
      ST_DIV_DN,
      ST_SQ_DN,
      ST_DN_SAVE,
      ST_MUL_RAMP,
      ST_MUL_SPEED,
      ST_FINISH
   } ctrl_state_type;

   typedef enum logic [1:0] {
      MUL_F_SQ,
      MUL_G_SQ,
      MUL_RAMP,
      MUL_SPEED
   } mul_sel_type;

   typedef enum logic {
      UP_FULL,
      UP_PROD
   } up_src_type;

   typedef enum logic [1:0] {
      DN_FULL,
      DN_ZERO,
      DN_PROD
   } dn_src_type;

   typedef struct packed {
      logic        load_req;
      logic        calc_time;
      logic        div_init;
      logic        div_sel_es;
      logic        div_step;
      logic        mul_go;
      mul_sel_type mul_sel;
      logic        up_load;
      up_src_type  up_src;
      logic        dn_load;
      dn_src_type  dn_src;
      logic        commit;
   } dp_cmd_type;

   typedef struct packed {
      logic [REQ_W-1:0] req_type;
      logic             run_stopped;
      logic             stop_wait;
      logic             el_lt_ramp;
      logic             es_lt_ramp;
      logic             out_free;
   } dp_status_type;

   typedef struct packed {
      logic                  we;
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] wdata;
   } csr_wr_type;

endpackage

### src/lfsrc_if.sv
// Channel interfaces: request, response and register write.
interface lfsrc_req_if
   import lfsrc_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [REQ_W-1:0]        req_type;
   logic [TIME_W-1:0]       now_ms;
   logic [FLAGS_W-1:0]      black_flags;
   logic signed [DEV_W-1:0] deviation;

   modport source (output valid, req_type, now_ms, black_flags, deviation, input ready);
   modport sink   (input valid, req_type, now_ms, black_flags, deviation, output ready);
endinterface

interface lfsrc_rsp_if
   import lfsrc_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic                       drive_valid;
   logic                       stop_motor;
   logic signed [TARGET_W-1:0] left_target;
   logic signed [TARGET_W-1:0] right_target;
   logic                       is_stopped;
   logic                       stop_armed;
   logic [FRAMES_W-1:0]        frame_count;
   logic [TIME_W-1:0]          lap_time_ms;

   modport source (output valid, drive_valid, stop_motor, left_target, right_target,
                   is_stopped, stop_armed, frame_count, lap_time_ms, input ready);
   modport sink   (input valid, drive_valid, stop_motor, left_target, right_target,
                   is_stopped, stop_armed, frame_count, lap_time_ms, output ready);
endinterface

interface lfsrc_csr_if
   import lfsrc_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

### src/lfsrc_div.sv
// Restoring divider: Q16 fraction numer/denom, one quotient bit per cycle while step is high.
module lfsrc_div
   import lfsrc_pkg::*;
(
   input  logic              clock,
   input  logic              init,
   input  logic              step,
   input  logic [RAMP_W-1:0] numer,
   input  logic [RAMP_W-1:0] denom,
   output logic [RAMP_W-1:0] quo
);

   logic [RAMP_W-1:0] rem_ff, rem_in;
   logic [RAMP_W-1:0] quo_ff, quo_in;
   logic [RAMP_W+1:0] trial;

   // numer < denom, so the remainder always fits RAMP_W bits
   assign trial = {1'b0, rem_ff, 1'b0} - {2'b00, denom};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (init) begin
         rem_in = numer;
         quo_in = '0;
      end else if (step) begin
         rem_in = trial[RAMP_W+1] ? {rem_ff[RAMP_W-2:0], 1'b0} : trial[RAMP_W-1:0];
         quo_in = {quo_ff[RAMP_W-2:0], ~trial[RAMP_W+1]};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quo = quo_ff;

endmodule

### src/lfsrc_ctrl.sv
// Sequencer FSM: steps the datapath through one request.
module lfsrc_ctrl
   import lfsrc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

   ctrl_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (status.req_type == REQ_DRIVE && !status.run_stopped) state_in = ST_UP_INIT;
            else state_in = ST_FINISH;
         end
         ST_UP_INIT: begin
            state_in = status.el_lt_ramp ? ST_DIV_UP : ST_DN_INIT;
         end
         ST_DIV_UP: begin
            if (step_ff == STEP_LAST) state_in = ST_SQ_UP;
         end
         ST_SQ_UP:   state_in = ST_UP_SAVE;
         ST_UP_SAVE: state_in = ST_DN_INIT;
         ST_DN_INIT: begin
            if (status.stop_wait && status.es_lt_ramp) state_in = ST_DIV_DN;
            else state_in = ST_MUL_RAMP;
         end
         ST_DIV_DN: begin
            if (step_ff == STEP_LAST) state_in = ST_SQ_DN;
         end
         ST_SQ_DN:     state_in = ST_DN_SAVE;
         ST_DN_SAVE:   state_in = ST_MUL_RAMP;
         ST_MUL_RAMP:  state_in = ST_MUL_SPEED;
         ST_MUL_SPEED: state_in = ST_FINISH;
         ST_FINISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign step_in = (state_ff == ST_DIV_UP || state_ff == ST_DIV_DN) ? step_ff + 1'b1 : '0;

   always_comb begin
      cmd         = '0;
      cmd.mul_sel = MUL_F_SQ;
      cmd.up_src  = UP_FULL;
      cmd.dn_src  = DN_FULL;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_DECODE: cmd.calc_time = 1'b1;
         ST_UP_INIT: begin
            if (status.el_lt_ramp) begin
               cmd.div_init = 1'b1;
            end else begin
               cmd.up_load = 1'b1;
               cmd.up_src  = UP_FULL;
            end
         end
         ST_DIV_UP: cmd.div_step = 1'b1;
         ST_SQ_UP: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_F_SQ;
         end
         ST_UP_SAVE: begin
            cmd.up_load = 1'b1;
            cmd.up_src  = UP_PROD;
         end
         ST_DN_INIT: begin
            if (!status.stop_wait) begin
               cmd.dn_load = 1'b1;
               cmd.dn_src  = DN_FULL;
            end else if (status.es_lt_ramp) begin
               cmd.div_init   = 1'b1;
               cmd.div_sel_es = 1'b1;
            end else begin
               cmd.dn_load = 1'b1;
               cmd.dn_src  = DN_ZERO;
            end
         end
         ST_DIV_DN: cmd.div_step = 1'b1;
         ST_SQ_DN: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_G_SQ;
         end
         ST_DN_SAVE: begin
            cmd.dn_load = 1'b1;
            cmd.dn_src  = DN_PROD;
         end
         ST_MUL_RAMP: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_RAMP;
         end
         ST_MUL_SPEED: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_SPEED;
         end
         ST_FINISH: cmd.commit = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

### src/lfsrc_dp.sv
// Datapath: run state, registers, divider, shared multiplier, result register.
module lfsrc_dp
   import lfsrc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  dp_cmd_type                 cmd,
   output dp_status_type              status,
   input  csr_wr_type                 csr_wr,
   input  logic [REQ_W-1:0]           req_type,
   input  logic [TIME_W-1:0]          now_ms,
   input  logic [FLAGS_W-1:0]         black_flags,
   input  logic signed [DEV_W-1:0]    deviation,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic                       drive_valid,
   output logic                       stop_motor,
   output logic signed [TARGET_W-1:0] left_target,
   output logic signed [TARGET_W-1:0] right_target,
   output logic                       is_stopped,
   output logic                       stop_armed,
   output logic [FRAMES_W-1:0]        frame_count,
   output logic [TIME_W-1:0]          lap_time_ms
);

   // registers
   logic [SPEED_W-1:0]  base_speed_ff;
   logic [FRAMES_W-1:0] stop_frames_ff;
   logic [RAMP_W-1:0]   ramp_time_ff;

   // latched request and working values
   logic [REQ_W-1:0]        type_ff;
   logic [TIME_W-1:0]       now_ff;
   logic [FLAGS_W-1:0]      flags_ff;
   logic signed [DEV_W-1:0] dev_ff;
   logic [TIME_W-1:0]       el_ff, es_ff;
   logic [Q16_W-1:0]        up_ff, dn_ff;
   logic [PROD_W-1:0]       prod_ff;

   // run state
   logic [TIME_W-1:0]   lap_origin_ff, lap_origin_in;
   logic [TIME_W-1:0]   stop_start_ff, stop_start_in;
   logic [TIME_W-1:0]   lost_start_ff, lost_start_in;
   logic                lost_armed_ff, lost_armed_in;
   logic                stopped_ff, stopped_in;
   logic                pending_ff, pending_in;
   logic [FRAMES_W-1:0] frames_ff, frames_in;
   logic [TIME_W-1:0]   frozen_ff, frozen_in;

   // result register
   logic                rsp_valid_ff;
   logic                drive_ff, stop_ff;
   logic [TARGET_W-1:0] left_ff, right_ff;
   logic                is_stopped_ff, armed_ff;
   logic [FRAMES_W-1:0] count_ff;
   logic [TIME_W-1:0]   lap_ff;

   logic                drive_c, stop_now_c;
   logic [TARGET_W-1:0] left_c, right_c;

   logic [RAMP_W-1:0] div_numer, quo;
   logic [Q16_W-1:0]  g_q16, mul_a, mul_b, prod_hi;
   logic [TARGET_W-1:0] ramped, dev_ext;
   logic [2:0]          black_cnt;
   logic [FRAMES_W-1:0] frames_sat;
   logic                out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_speed_ff  <= BASE_SPEED_RST;
         stop_frames_ff <= STOP_FRAMES_RST;
         ramp_time_ff   <= RAMP_TIME_RST;
      end else if (csr_wr.we) begin
         unique case (csr_wr.addr)
            CSR_BASE_SPEED:  base_speed_ff  <= csr_wr.wdata[SPEED_W-1:0];
            CSR_STOP_FRAMES: stop_frames_ff <= csr_wr.wdata[FRAMES_W-1:0];
            CSR_RAMP_TIME:   ramp_time_ff   <= csr_wr.wdata[RAMP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         type_ff  <= req_type;
         now_ff   <= now_ms;
         flags_ff <= black_flags;
         dev_ff   <= deviation;
      end
      if (cmd.calc_time) begin
         el_ff <= now_ff - lap_origin_ff;
         es_ff <= now_ff - stop_start_ff;
      end
   end

   assign div_numer = cmd.div_sel_es ? es_ff[RAMP_W-1:0] : el_ff[RAMP_W-1:0];

   lfsrc_div u_div (
      .clock (clock),
      .init  (cmd.div_init),
      .step  (cmd.div_step),
      .numer (div_numer),
      .denom (ramp_time_ff),
      .quo   (quo)
   );

   // shared multiplier, one product per command
   assign g_q16   = Q16_ONE - {1'b0, quo};
   assign prod_hi = prod_ff[Q16_W+15:16];

   always_comb begin
      unique case (cmd.mul_sel)
         MUL_F_SQ: begin
            mul_a = {1'b0, quo};
            mul_b = {1'b0, quo};
         end
         MUL_G_SQ: begin
            mul_a = g_q16;
            mul_b = g_q16;
         end
         MUL_RAMP: begin
            mul_a = up_ff;
            mul_b = dn_ff;
         end
         MUL_SPEED: begin
            mul_a = {{(Q16_W-SPEED_W){1'b0}}, base_speed_ff};
            mul_b = prod_hi;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_go) prod_ff <= mul_a * mul_b;
      if (cmd.up_load) up_ff <= (cmd.up_src == UP_PROD) ? prod_hi : Q16_ONE;
      if (cmd.dn_load) begin
         unique case (cmd.dn_src)
            DN_FULL: dn_ff <= Q16_ONE;
            DN_ZERO: dn_ff <= '0;
            DN_PROD: dn_ff <= Q16_ONE - prod_hi;
            default: dn_ff <= '0;
         endcase
      end
   end

   // commit of one request
   assign ramped     = prod_ff[TARGET_W+15:16];
   assign dev_ext    = {{(TARGET_W-DEV_W){dev_ff[DEV_W-1]}}, dev_ff};
   assign black_cnt  = {2'b00, flags_ff[3]} + {2'b00, flags_ff[4]}
                     + {2'b00, flags_ff[5]} + {2'b00, flags_ff[6]};
   assign frames_sat = (frames_ff == FRAMES_MAX) ? frames_ff : frames_ff + 1'b1;

   always_comb begin
      lap_origin_in = lap_origin_ff;
      stop_start_in = stop_start_ff;
      lost_start_in = lost_start_ff;
      lost_armed_in = lost_armed_ff;
      stopped_in    = stopped_ff;
      pending_in    = pending_ff;
      frames_in     = frames_ff;
      frozen_in     = frozen_ff;
      drive_c       = 1'b0;
      stop_now_c    = 1'b0;
      left_c        = '0;
      right_c       = '0;
      unique case (type_ff)
         REQ_START: begin
            lap_origin_in = now_ff;
            stopped_in    = 1'b0;
            pending_in    = 1'b0;
            lost_armed_in = 1'b0;
            frames_in     = '0;
            frozen_in     = '0;
         end
         REQ_LINE: begin
            if (!stopped_ff && !pending_ff && el_ff >= LINE_START_MS) begin
               if (black_cnt >= LINE_BLACK_MIN) begin
                  frames_in = frames_sat;
                  if (frames_sat >= stop_frames_ff) begin
                     pending_in    = 1'b1;
                     stop_start_in = now_ff;
                  end
               end else begin
                  frames_in = '0;
               end
            end
         end
         REQ_DRIVE: begin
            if (!stopped_ff) begin
               if (flags_ff == '0) begin
                  lost_armed_in = 1'b1;
                  // first white frame starts the lost-line timer
                  lost_start_in = lost_armed_ff ? lost_start_ff : now_ff;
                  stop_now_c    = (now_ff - lost_start_in) >= LOST_STOP_MS;
               end else begin
                  lost_armed_in = 1'b0;
               end
               if (pending_ff && dn_ff == '0) stop_now_c = 1'b1;
               if (stop_now_c) begin
                  stopped_in = 1'b1;
                  frozen_in  = el_ff;
               end else begin
                  drive_c = 1'b1;
                  left_c  = ramped + dev_ext;
                  right_c = ramped - dev_ext;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lap_origin_ff <= '0;
         stop_start_ff <= '0;
         lost_start_ff <= '0;
         lost_armed_ff <= 1'b0;
         stopped_ff    <= 1'b0;
         pending_ff    <= 1'b0;
         frames_ff     <= '0;
         frozen_ff     <= '0;
      end else if (cmd.commit) begin
         lap_origin_ff <= lap_origin_in;
         stop_start_ff <= stop_start_in;
         lost_start_ff <= lost_start_in;
         lost_armed_ff <= lost_armed_in;
         stopped_ff    <= stopped_in;
         pending_ff    <= pending_in;
         frames_ff     <= frames_in;
         frozen_ff     <= frozen_in;
      end
   end

   // result register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.commit) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         drive_ff      <= drive_c;
         stop_ff       <= stop_now_c;
         left_ff       <= left_c;
         right_ff      <= right_c;
         is_stopped_ff <= stopped_in;
         armed_ff      <= pending_in;
         count_ff      <= frames_in;
         lap_ff        <= stopped_in ? frozen_in : '0;
      end
   end

   assign status.req_type    = type_ff;
   assign status.run_stopped = stopped_ff;
   assign status.stop_wait   = pending_ff;
   assign status.el_lt_ramp  = el_ff < {{(TIME_W-RAMP_W){1'b0}}, ramp_time_ff};
   assign status.es_lt_ramp  = es_ff < {{(TIME_W-RAMP_W){1'b0}}, ramp_time_ff};
   assign status.out_free    = out_free;

   assign rsp_valid    = rsp_valid_ff;
   assign drive_valid  = drive_ff;
   assign stop_motor   = stop_ff;
   assign left_target  = signed'(left_ff);
   assign right_target = signed'(right_ff);
   assign is_stopped   = is_stopped_ff;
   assign stop_armed   = armed_ff;
   assign frame_count  = count_ff;
   assign lap_time_ms  = lap_ff;

endmodule

### src/line_follow_stop_ramp_control.sv
// Line-follower drive sequencer top level: FSM plus datapath.
// A drive update with soft start and soft stop both active runs two 16-step serial
// divisions and four multiplier passes, with one of them active one division and three
// passes, with neither two passes; other requests skip the arithmetic. A stalled
// result register holds the FSM in its finish state until the result is taken.
// Reset (synchronous, active high) clears run state, loads register defaults.
`include "assert_macros.svh"

module line_follow_stop_ramp_control
   import lfsrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   lfsrc_req_if.sink   req_chan,
   lfsrc_rsp_if.source rsp_chan,
   lfsrc_csr_if.sink   csr_chan
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;
   csr_wr_type    csr_wr;

   // register writes are always taken
   assign csr_chan.ready = 1'b1;
   assign csr_wr.we      = csr_chan.valid;
   assign csr_wr.addr    = csr_chan.addr;
   assign csr_wr.wdata   = csr_chan.wdata;

   lfsrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   lfsrc_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (dp_cmd),
      .status       (dp_status),
      .csr_wr       (csr_wr),
      .req_type     (req_chan.req_type),
      .now_ms       (req_chan.now_ms),
      .black_flags  (req_chan.black_flags),
      .deviation    (req_chan.deviation),
      .rsp_ready    (rsp_chan.ready),
      .rsp_valid    (rsp_chan.valid),
      .drive_valid  (rsp_chan.drive_valid),
      .stop_motor   (rsp_chan.stop_motor),
      .left_target  (rsp_chan.left_target),
      .right_target (rsp_chan.right_target),
      .is_stopped   (rsp_chan.is_stopped),
      .stop_armed   (rsp_chan.stop_armed),
      .frame_count  (rsp_chan.frame_count),
      .lap_time_ms  (rsp_chan.lap_time_ms)
   );

   logic req_xfer, rsp_running, drive_and_stop;

   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_running    = rsp_chan.valid && !rsp_chan.is_stopped;
   assign drive_and_stop = rsp_chan.drive_valid && rsp_chan.stop_motor;

   `ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_xfer, !req_chan.ready, "taken while busy")
   `ASSERT_IMPLY(a_commit_slot_free, clock, reset, dp_cmd.commit, dp_status.out_free, "overwrite")
   `ASSERT_IMPLY(a_lap_zero_running, clock, reset, rsp_running, rsp_chan.lap_time_ms == '0, "lap time")
   `ASSERT_IMPLY(a_drive_or_stop, clock, reset, rsp_chan.valid, !drive_and_stop, "drive and stop")

endmodule
